[src/hhf_pkg.sv]
`default_nettype none
package hhf_pkg;

	localparam int unsigned MaxWidth  = 256;
	localparam int unsigned MaxHeight = 256;
	localparam int unsigned PixelBits = 32;
	localparam int unsigned Depth     = MaxWidth * MaxHeight;
	localparam int unsigned AddrBits  = $clog2(Depth);
	localparam int unsigned ColBits   = $clog2(MaxWidth);
	localparam int unsigned RowBits   = $clog2(MaxHeight);
	localparam int unsigned DimBits   = 9;
	localparam int unsigned StepBits  = 16;
	localparam int unsigned IterBits  = 16;
	localparam int unsigned CfgBits   = 16;
	localparam int unsigned LapBits   = PixelBits + 3;
	localparam int unsigned ProdBits  = LapBits + StepBits + 1;
	localparam int unsigned ChgBits   = 31;
	localparam int unsigned MemBits   = PixelBits + 1;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_LOAD = 2'd0;
	localparam cmd_t CMD_RUN  = 2'd1;
	localparam cmd_t CMD_READ = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_STEP   = 2'd2;
	localparam cfg_idx_t CFG_ITER   = 2'd3;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef enum logic [2:0] {
		ADDR_IN,
		ADDR_C,
		ADDR_R,
		ADDR_D,
		ADDR_L,
		ADDR_U
	} addr_sel_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		logic      load_we;
		logic      upd_we;
		logic      center_ld;
		logic      acc_add;
		logic      mul_en;
		logic      run_init;
		logic      pass_next;
		logic      pos_step;
		logic      rd_done;
		logic      run_done;
	} ctl_t;

	typedef struct packed {
		logic hole;
		logic last_pix;
		logic last_pass;
		logic no_pass;
	} stat_t;

endpackage
`default_nettype wire

[src/hhf_ram.sv]
`default_nettype none
module hhf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

[src/hhf_datapath.sv]
`default_nettype none
module hhf_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire hhf_pkg::ctl_t                      ctl,
	output hhf_pkg::stat_t                          stat,
	input  wire logic [hhf_pkg::AddrBits-1:0]       pixel_index,
	input  wire logic signed [hhf_pkg::PixelBits-1:0] pixel_value,
	input  wire logic signed [hhf_pkg::PixelBits-1:0] init_value,
	input  wire logic                               is_hole,
	input  wire logic                               cfg_we,
	input  wire hhf_pkg::cfg_idx_t                  cfg_index,
	input  wire logic [hhf_pkg::CfgBits-1:0]        cfg_data,
	output logic                                    result_valid,
	output logic                                    result_kind,
	output logic signed [hhf_pkg::PixelBits-1:0]    pixel_out,
	output logic [hhf_pkg::ChgBits-1:0]             max_update
);
	import hhf_pkg::*;

	logic [DimBits-1:0]  width_q, height_q, w_act, h_act;
	logic [StepBits-1:0] step_q;
	logic [IterBits-1:0] iter_q, pass_q;
	logic [ColBits-1:0]  col_q;
	logic [RowBits-1:0]  row_q;
	logic [AddrBits-1:0] idx_q, addr;
	logic [MemBits-1:0]  wdata, rdata;
	logic                we;
	logic signed [PixelBits-1:0] c_q, rpix, nv;
	logic signed [LapBits-1:0]   sum_q;
	logic signed [ProdBits-1:0]  prod_s1;
	logic signed [ProdBits-1:0]  biased;
	logic signed [ProdBits-16-1:0] stepv;
	logic signed [ProdBits-16:0] nv_full;
	logic signed [PixelBits:0]   diff;
	logic [PixelBits:0]          mag;
	logic [ChgBits-1:0]          chg, best_q;
	logic                        last_col, last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimBits'(MaxWidth);
			height_q <= DimBits'(MaxHeight);
			step_q   <= StepBits'(16384);
			iter_q   <= IterBits'(100);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[DimBits-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DimBits-1:0];
				CFG_STEP:   step_q   <= cfg_data[StepBits-1:0];
				CFG_ITER:   iter_q   <= cfg_data[IterBits-1:0];
			endcase
		end
	end

	// Zero counts as one, anything past the maximum as the maximum.
	always_comb begin
		w_act = width_q;
		if (width_q == '0) w_act = DimBits'(1);
		else if (width_q > DimBits'(MaxWidth)) w_act = DimBits'(MaxWidth);
		h_act = height_q;
		if (height_q == '0) h_act = DimBits'(1);
		else if (height_q > DimBits'(MaxHeight)) h_act = DimBits'(MaxHeight);
	end

	assign last_col = {1'b0, col_q} == w_act - DimBits'(1);
	assign last_row = {1'b0, row_q} == h_act - DimBits'(1);

	always_comb begin
		unique case (ctl.addr_sel)
			ADDR_IN: addr = pixel_index;
			ADDR_C:  addr = idx_q;
			ADDR_R:  addr = last_col ? idx_q : idx_q + AddrBits'(1);
			ADDR_D:  addr = last_row ? idx_q : idx_q + AddrBits'(w_act);
			ADDR_L:  addr = (col_q == '0) ? idx_q : idx_q - AddrBits'(1);
			ADDR_U:  addr = (row_q == '0) ? idx_q : idx_q - AddrBits'(w_act);
			default: addr = idx_q;
		endcase
	end

	assign we    = ctl.load_we | ctl.upd_we;
	assign wdata = ctl.load_we ? {is_hole, is_hole ? init_value : pixel_value} : {1'b1, nv};

	hhf_ram #(.WIDTH(MemBits), .DEPTH(Depth)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	assign rpix = rdata[PixelBits-1:0];

	always_ff @(posedge clk) begin
		if (ctl.center_ld) begin
			c_q   <= rpix;
			sum_q <= -(LapBits'(rpix) <<< 2);
		end else if (ctl.acc_add) begin
			sum_q <= sum_q + LapBits'(rpix);
		end
		if (ctl.mul_en) begin
			prod_s1 <= sum_q * $signed({1'b0, step_q});
		end
	end

	// Round to nearest with ties toward plus infinity, then saturate.
	assign biased  = prod_s1 + ProdBits'(32'h8000);
	assign stepv   = biased[ProdBits-1:16];
	assign nv_full = (ProdBits-15)'(stepv) + (ProdBits-15)'(c_q);
	always_comb begin
		if (nv_full > (ProdBits-15)'(signed'({1'b0, {(PixelBits-1){1'b1}}})))
			nv = {1'b0, {(PixelBits-1){1'b1}}};
		else if (nv_full < (ProdBits-15)'(signed'({1'b1, {(PixelBits-1){1'b0}}})))
			nv = {1'b1, {(PixelBits-1){1'b0}}};
		else
			nv = nv_full[PixelBits-1:0];
	end
	assign diff = (PixelBits+1)'(nv) - (PixelBits+1)'(c_q);
	assign mag  = diff[PixelBits] ? unsigned'(-diff) : unsigned'(diff);
	assign chg  = (mag > (PixelBits+1)'({ChgBits{1'b1}})) ? {ChgBits{1'b1}} : mag[ChgBits-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			idx_q        <= '0;
			pass_q       <= '0;
			best_q       <= '0;
			result_valid <= 1'b0;
			result_kind  <= KIND_READ;
			pixel_out    <= '0;
			max_update   <= '0;
		end else begin
			result_valid <= ctl.rd_done | ctl.run_done;
			if (ctl.run_init || ctl.pass_next) begin
				col_q  <= '0;
				row_q  <= '0;
				idx_q  <= '0;
				best_q <= '0;
				pass_q <= ctl.run_init ? '0 : pass_q + IterBits'(1);
			end else if (ctl.pos_step) begin
				idx_q <= idx_q + AddrBits'(1);
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + RowBits'(1);
				end else begin
					col_q <= col_q + ColBits'(1);
				end
			end
			// The change of a pass that is not the last one is never reported.
			if (ctl.upd_we && !ctl.pass_next && chg > best_q) begin
				best_q <= chg;
			end
			if (ctl.rd_done) begin
				result_kind <= KIND_READ;
				pixel_out   <= rpix;
				max_update  <= '0;
			end else if (ctl.run_done) begin
				result_kind <= KIND_RUN;
				pixel_out   <= '0;
				max_update  <= best_q;
			end
		end
	end

	assign stat.hole      = rdata[PixelBits];
	assign stat.last_pix  = last_col & last_row;
	assign stat.last_pass = pass_q == iter_q - IterBits'(1);
	assign stat.no_pass   = iter_q == '0;
endmodule
`default_nettype wire

[src/hhf_ctrl.sv]
`default_nettype none
module hhf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire hhf_pkg::cmd_t  cmd,
	input  wire hhf_pkg::stat_t stat,
	output hhf_pkg::ctl_t       ctl,
	output logic                busy
);
	import hhf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_CISSUE, S_CWAIT, S_NR, S_ND, S_NL, S_NU, S_MUL, S_UPD, S_FIN
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		ctl      = '0;
		ctl.addr_sel = ADDR_C;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.addr_sel = ADDR_IN;
				if (start) begin
					unique case (cmd)
						CMD_LOAD: ctl.load_we = 1'b1;
						CMD_RUN: begin
							ctl.run_init = 1'b1;
							state_d = stat.no_pass ? S_FIN : S_CISSUE;
						end
						CMD_READ: state_d = S_READ;
						default: ;
					endcase
				end
			end
			S_READ: begin
				ctl.rd_done = 1'b1;
				state_d = S_IDLE;
			end
			S_CISSUE: state_d = S_CWAIT;
			S_CWAIT: begin
				ctl.center_ld = 1'b1;
				ctl.addr_sel  = ADDR_R;
				if (stat.hole) begin
					state_d = S_NR;
				end else if (stat.last_pix) begin
					ctl.pass_next = !stat.last_pass;
					state_d = stat.last_pass ? S_FIN : S_CISSUE;
				end else begin
					ctl.pos_step = 1'b1;
					state_d = S_CISSUE;
				end
			end
			S_NR: begin
				ctl.acc_add  = 1'b1;
				ctl.addr_sel = ADDR_D;
				state_d = S_ND;
			end
			S_ND: begin
				ctl.acc_add  = 1'b1;
				ctl.addr_sel = ADDR_L;
				state_d = S_NL;
			end
			S_NL: begin
				ctl.acc_add  = 1'b1;
				ctl.addr_sel = ADDR_U;
				state_d = S_NU;
			end
			S_NU: begin
				ctl.acc_add = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				ctl.mul_en = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				ctl.upd_we = 1'b1;
				if (stat.last_pix) begin
					ctl.pass_next = !stat.last_pass;
					state_d = stat.last_pass ? S_FIN : S_CISSUE;
				end else begin
					ctl.pos_step = 1'b1;
					state_d = S_CISSUE;
				end
			end
			S_FIN: begin
				ctl.run_done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
endmodule
`default_nettype wire

[src/harmonic_hole_fill_unit.sv]
`default_nettype none
// Channel   Handshake             Payload
// request   start / busy          cmd, pixel_index, pixel_value, init_value, is_hole
// config    cfg_we                cfg_index, cfg_data
// result    result_valid strobe   result_kind, pixel_out, max_update
//
// A load request is written in the cycle it is accepted; busy stays low. A read
// request raises busy in its read state and the registered result strobes in
// the cycle after that state. A run request visits, per pass, an issue and a
// wait state for each pixel of the active area, and for each hole pixel also
// states that finish five reads of the single image memory port, fold in the
// last neighbor, multiply and write back; a finish state ends the run. The
// receiver cannot stall: every result is shown for exactly one cycle. Reset
// restores the register defaults; image memory contents are undefined until loaded.
module harmonic_hole_fill_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire hhf_pkg::cmd_t                        cmd,
	input  wire logic [15:0]                          pixel_index,
	input  wire logic signed [31:0]                   pixel_value,
	input  wire logic signed [31:0]                   init_value,
	input  wire logic                                 is_hole,
	input  wire logic                                 cfg_we,
	input  wire hhf_pkg::cfg_idx_t                    cfg_index,
	input  wire logic [hhf_pkg::CfgBits-1:0]          cfg_data,
	output logic                                      result_valid,
	output logic                                      result_kind,
	output logic signed [31:0]                        pixel_out,
	output logic [30:0]                               max_update
);
	import hhf_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	// The controller sequences every request; the datapath owns the memory,
	// the pixel position counters and the arithmetic.
	hhf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	hhf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.pixel_index  (pixel_index),
		.pixel_value  (pixel_value),
		.init_value   (init_value),
		.is_hole      (is_hole),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.pixel_out    (pixel_out),
		.max_update   (max_update)
	);

	a_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_RUN |-> !busy)
		else $error("run result while still busy");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_READ |-> max_update == '0)
		else $error("read result carries a change value");

	a_run_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_RUN |-> pixel_out == '0)
		else $error("run result carries pixel data");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_LOAD |=> !result_valid)
		else $error("load request produced a result");
endmodule
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
	import hhf_pkg::*;

	// The fourth command code has no meaning; the block must drop it silently.
	localparam cmd_t CMD_NONE = 2'd3;
	localparam int unsigned AreaMax = 256;

	// One expected result of a read or run request.
	typedef struct {
		logic        kind;
		logic [31:0] pixel;
		logic [30:0] change;
	} fill_result_t;

	// Tracks the image store, the hole flags and the registers, and predicts
	// what each accepted request must return.
	class hole_fill_board;
		logic signed [31:0] pix_mem[int];
		bit                 hole_mem[int];
		int                 loaded[$];
		logic [8:0]         width_reg = 9'd256;
		logic [8:0]         height_reg = 9'd256;
		logic [15:0]        step_reg = 16'd16384;
		logic [15:0]        iter_reg = 16'd100;
		fill_result_t       pending[$];
		int                 errors = 0;

		function void write_reg(cfg_idx_t idx, logic [15:0] data);
			case (idx)
				CFG_WIDTH:  width_reg = data[8:0];
				CFG_HEIGHT: height_reg = data[8:0];
				CFG_STEP:   step_reg = data;
				CFG_ITER:   iter_reg = data;
			endcase
		endfunction

		function int active_dim(logic [8:0] v);
			if (v == 0) return 1;
			if (v > AreaMax) return AreaMax;
			return int'(v);
		endfunction

		function longint neighbor(int w, int h, int col, int row);
			if (col < 0) col = 0;
			if (row < 0) row = 0;
			if (col >= w) col = w - 1;
			if (row >= h) row = h - 1;
			return longint'(pix_mem[row * w + col]);
		endfunction

		// Laplacian times step in unsigned Q0.16, rounded to nearest, ties upward.
		function longint scaled_step(longint lap);
			longint unsigned u;
			longint unsigned r;
			longint          q;
			longint          frac;
			longint          ts;
			ts = longint'({48'd0, step_reg});
			u = longint'(lap) + (64'd1 << 56);
			q = longint'(u >> 16) - (longint'(1) << 40);
			r = u & 64'hFFFF;
			frac = longint'((r * longint'(ts) + 64'h8000) >> 16);
			return q * ts + frac;
		endfunction

		function longint relax_pass(int w, int h);
			longint best;
			longint c;
			longint lap;
			longint nv;
			longint d;
			int     idx;
			best = 0;
			for (int row = 0; row < h; row++) begin
				for (int col = 0; col < w; col++) begin
					idx = row * w + col;
					if (!hole_mem[idx]) continue;
					c = longint'(pix_mem[idx]);
					lap = -4 * c + neighbor(w, h, col + 1, row) + neighbor(w, h, col, row + 1)
						+ neighbor(w, h, col - 1, row) + neighbor(w, h, col, row - 1);
					nv = c + scaled_step(lap);
					if (nv > 64'sd2147483647) nv = 64'sd2147483647;
					if (nv < -64'sd2147483648) nv = -64'sd2147483648;
					d = nv - c;
					if (d < 0) d = -d;
					if (d > 64'sd2147483647) d = 64'sd2147483647;
					if (d > best) best = d;
					pix_mem[idx] = nv[31:0];
				end
			end
			return best;
		endfunction

		function void note_request(cmd_t c, logic [15:0] idx, logic [31:0] pv,
				logic [31:0] iv, logic h);
			fill_result_t r;
			int           w;
			int           ht;
			longint       best;
			case (c)
				CMD_LOAD: begin
					if (!pix_mem.exists(int'(idx))) loaded.push_back(int'(idx));
					pix_mem[int'(idx)] = h ? iv : pv;
					hole_mem[int'(idx)] = h;
				end
				CMD_RUN: begin
					w = active_dim(width_reg);
					ht = active_dim(height_reg);
					best = 0;
					for (int k = 0; k < int'(iter_reg); k++) best = relax_pass(w, ht);
					r.kind = KIND_RUN;
					r.pixel = '0;
					r.change = best[30:0];
					pending.push_back(r);
				end
				CMD_READ: begin
					r.kind = KIND_READ;
					r.pixel = pix_mem[int'(idx)];
					r.change = '0;
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic kind, logic [31:0] pixel, logic [30:0] change);
			fill_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing outstanding: kind %0d", kind);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (kind !== e.kind) begin
				$error("result_kind expected %0d got %0d", e.kind, kind);
				errors++;
			end
			if (pixel !== e.pixel) begin
				$error("pixel_out expected %h got %h", e.pixel, pixel);
				errors++;
			end
			if (change !== e.change) begin
				$error("max_update expected %h got %h", e.change, change);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cmd_t               cmd;
	logic [15:0]        pixel_index;
	logic signed [31:0] pixel_value;
	logic signed [31:0] init_value;
	logic               is_hole;
	logic               cfg_we;
	cfg_idx_t           cfg_index;
	logic [CfgBits-1:0] cfg_data;
	logic               result_valid;
	logic               result_kind;
	logic signed [31:0] pixel_out;
	logic [30:0]        max_update;

	hole_fill_board board = new();
	int idle_pct = 0;

	harmonic_hole_fill_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.pixel_index(pixel_index), .pixel_value(pixel_value), .init_value(init_value),
		.is_hole(is_hole), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result_kind(result_kind), .pixel_out(pixel_out),
		.max_update(max_update)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every strobed result is taken at the edge that ends its cycle; the values
	// seen here are the ones held during that cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid) board.check_result(result_kind, pixel_out, max_update);
	end

	// Issues one request and returns once the block has accepted it. Random
	// idle cycles go in front so that gaps land on every phase of the block.
	task automatic send_request(cmd_t c, logic [15:0] idx, logic [31:0] pv,
			logic [31:0] iv, logic h);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		pixel_index <= idx;
		pixel_value <= pv;
		init_value <= iv;
		is_hole <= h;
		do @(posedge clk); while (busy);
		board.note_request(c, idx, pv, iv, h);
	endtask

	// Registers may only change with the block idle, so drain all outstanding
	// results first and then leave a few cycles for any trailing load.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] ts,
			logic [15:0] iter);
		wait_idle();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_STEP, ts);
		write_reg(CFG_ITER, iter);
	endtask

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
			default: return $urandom;
		endcase
	endfunction

	// A run reads every pixel of the active area, so each one is loaded before
	// any run can be issued under the new geometry.
	task automatic fill_area();
		int n;
		n = board.active_dim(board.width_reg) * board.active_dim(board.height_reg);
		for (int i = 0; i < n; i++)
			send_request(CMD_LOAD, 16'(i), random_pixel(), random_pixel(), 1'($urandom));
	endtask

	task automatic random_requests(int count);
		int          n;
		int          pick;
		logic [15:0] idx;
		n = board.active_dim(board.width_reg) * board.active_dim(board.height_reg);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				idx = ($urandom_range(9) < 7) ? 16'($urandom_range(n - 1)) : 16'($urandom);
				send_request(CMD_LOAD, idx, random_pixel(), random_pixel(), 1'($urandom));
			end else if (pick < 82) begin
				idx = 16'(board.loaded[$urandom_range(board.loaded.size() - 1)]);
				send_request(CMD_READ, idx, $urandom, $urandom, 1'($urandom));
			end else if (pick < 92) begin
				send_request(CMD_RUN, 16'($urandom), $urandom, $urandom, 1'($urandom));
			end else begin
				send_request(CMD_NONE, 16'($urandom), $urandom, $urandom, 1'($urandom));
			end
		end
	endtask

	initial begin
		logic [15:0] ts;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_LOAD;
		pixel_index = '0;
		pixel_value = '0;
		init_value = '0;
		is_hole = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A zero width and height both count as one pixel, and
		// the largest step and an empty run come first.
		configure(16'd0, 16'd0, 16'hFFFF, 16'd0);
		send_request(CMD_LOAD, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		send_request(CMD_RUN, 16'd0, 32'd0, 32'd0, 1'b0);
		send_request(CMD_READ, 16'd0, 32'd0, 32'd0, 1'b0);
		send_request(CMD_LOAD, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_request(CMD_READ, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_request(CMD_NONE, 16'h1234, 32'h1, 32'h2, 1'b1);
		send_request(CMD_LOAD, 16'h5A5A, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
		send_request(CMD_READ, 16'h5A5A, 32'd0, 32'd0, 1'b0);
		send_request(CMD_LOAD, 16'hA5A5, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_request(CMD_READ, 16'hA5A5, 32'd0, 32'd0, 1'b0);
		// The longest pass count on a lone hole pixel.
		configure(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		send_request(CMD_RUN, 16'd0, 32'd0, 32'd0, 1'b0);
		send_request(CMD_READ, 16'd0, 32'd0, 32'd0, 1'b0);

		// Oversized width clamps to the maximum; one wide single-row strip.
		configure(16'hFFFF, 16'd1, 16'd16384, 16'd2);
		fill_area();
		random_requests(10);

		// Random part: three idling regimes, each over several small geometries.
		for (int s = 0; s < 3; s++) begin
			idle_pct = (s == 0) ? 6 : (s == 1) ? 87 : 0;
			for (int b = 0; b < 3; b++) begin
				case ($urandom_range(3))
					0: ts = 16'd0;
					1: ts = 16'hFFFF;
					default: ts = 16'($urandom_range(16384));
				endcase
				configure({7'($urandom), 9'($urandom_range(8))},
					{7'($urandom), 9'($urandom_range(8))}, ts, 16'($urandom_range(6)));
				fill_area();
				random_requests(20);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
